// File: rtl/core/lscs_pkg.sv
// Shared types, constants and helpers for the line sensor calibrate and steer block.
`default_nettype none
package lscs_pkg;

  localparam int CHANNELS     = 5;
  localparam int SAMPLE_W     = 8;
  localparam int SPEED_W      = 8;
  localparam int ACTION_W     = 2;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 24;
  localparam int CFG_ADDR_W   = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_RUN    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_MAX_SPEED   = 2'd0,
    REG_SLIGHT_CUT  = 2'd1,
    REG_SHARP_CUT   = 2'd2,
    REG_CREEP_SPEED = 2'd3
  } reg_idx_t;

  localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 8'd240;
  localparam logic [SPEED_W-1:0] SLIGHT_CUT_RST  = 8'd80;
  localparam logic [SPEED_W-1:0] SHARP_CUT_RST   = 8'd210;
  localparam logic [SPEED_W-1:0] CREEP_SPEED_RST = 8'd20;

  // Steering patterns; channel 0 sits at the top bit.
  localparam logic [CHANNELS-1:0] PAT_EDGE_B  = 5'h01;
  localparam logic [CHANNELS-1:0] PAT_OUTER_B = 5'h02;
  localparam logic [CHANNELS-1:0] PAT_PAIR_B  = 5'h03;
  localparam logic [CHANNELS-1:0] PAT_MID_B   = 5'h06;
  localparam logic [CHANNELS-1:0] PAT_CENTER  = 5'h04;
  localparam logic [CHANNELS-1:0] PAT_MID_A   = 5'h0C;
  localparam logic [CHANNELS-1:0] PAT_PAIR_A  = 5'h18;
  localparam logic [CHANNELS-1:0] PAT_OUTER_A = 5'h08;
  localparam logic [CHANNELS-1:0] PAT_EDGE_A  = 5'h10;

  typedef struct packed {
    logic [SPEED_W-1:0] creep_speed;
    logic [SPEED_W-1:0] sharp_cut;
    logic [SPEED_W-1:0] slight_cut;
    logic [SPEED_W-1:0] max_speed;
  } cfg_t;

  // Packed so the first output field lands in the lowest bits.
  typedef struct packed {
    logic [SPEED_W-1:0]  right_drive;
    logic [SPEED_W-1:0]  left_drive;
    logic                pattern_known;
    logic [CHANNELS-1:0] sensor_pattern;
  } result_t;

  function automatic logic [SPEED_W-1:0] sat_sub(input logic [SPEED_W-1:0] a,
                                                 input logic [SPEED_W-1:0] b);
    sat_sub = (a > b) ? (a - b) : '0;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lscs_lane.sv
// One sensor channel: min/max trackers, midpoint and threshold compare.
`default_nettype none
module lscs_lane
  import lscs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire action_t             action,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     hit
);

  logic [SAMPLE_W-1:0] low;
  logic [SAMPLE_W-1:0] high;
  logic [SAMPLE_W-1:0] mid;
  logic [SAMPLE_W-1:0] mid_next;
  logic signed [SAMPLE_W:0] diff;
  logic signed [SAMPLE_W:0] half;

  // signed halve, truncating toward zero
  always_comb begin
    diff     = $signed({1'b0, high}) - $signed({1'b0, low});
    half     = (diff + $signed({{SAMPLE_W{1'b0}}, diff[SAMPLE_W]})) >>> 1;
    mid_next = low + half[SAMPLE_W-1:0];
  end

  assign hit = (sample >= mid);

  always_ff @(posedge clk) begin
    if (rst) begin
      low  <= '1;
      high <= '0;
      mid  <= '0;
    end else if (accept) begin
      unique case (action)
        ACT_START: begin
          low  <= '1;
          high <= '0;
        end
        ACT_SAMPLE: begin
          if (sample < low)  low  <= sample;
          if (sample > high) high <= sample;
        end
        ACT_FINISH: begin
          mid <= mid_next;
        end
        ACT_RUN: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lscs_steer.sv
// Merge stage: pattern lookup, drive speeds and held speed registers.
`default_nettype none
module lscs_steer
  import lscs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire action_t             action,
  input  wire logic [CHANNELS-1:0] pattern,
  input  wire cfg_t                cfg,
  output result_t                  res
);

  logic [SPEED_W-1:0] held_left;
  logic [SPEED_W-1:0] held_right;
  logic [SPEED_W-1:0] left_next;
  logic [SPEED_W-1:0] right_next;
  logic               known;

  always_comb begin
    left_next  = held_left;
    right_next = held_right;
    known      = 1'b1;
    unique case (pattern)
      PAT_EDGE_B:  begin left_next = '0;              right_next = cfg.max_speed; end
      PAT_OUTER_B: begin left_next = cfg.creep_speed; right_next = cfg.max_speed; end
      PAT_PAIR_B:  begin
        left_next  = sat_sub(cfg.max_speed, cfg.sharp_cut);
        right_next = cfg.max_speed;
      end
      PAT_MID_B:   begin
        left_next  = sat_sub(cfg.max_speed, cfg.slight_cut);
        right_next = cfg.max_speed;
      end
      PAT_CENTER:  begin left_next = cfg.max_speed; right_next = cfg.max_speed; end
      PAT_MID_A:   begin
        left_next  = cfg.max_speed;
        right_next = sat_sub(cfg.max_speed, cfg.slight_cut);
      end
      PAT_PAIR_A:  begin
        left_next  = cfg.max_speed;
        right_next = sat_sub(cfg.max_speed, cfg.sharp_cut);
      end
      PAT_OUTER_A: begin left_next = cfg.max_speed; right_next = cfg.creep_speed; end
      PAT_EDGE_A:  begin left_next = cfg.max_speed; right_next = '0;              end
      default:     known = 1'b0;
    endcase
  end

  always_comb begin
    if (action == ACT_RUN) begin
      res.sensor_pattern = pattern;
      res.pattern_known  = known;
      res.left_drive     = left_next;
      res.right_drive    = right_next;
    end else begin
      res.sensor_pattern = '0;
      res.pattern_known  = 1'b0;
      res.left_drive     = held_left;
      res.right_drive    = held_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left  <= '0;
      held_right <= '0;
    end else if (accept && action == ACT_RUN) begin
      held_left  <= left_next;
      held_right <= right_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/line_sensor_calibrate_and_steer.sv
// Top level: config registers, five sensor lanes, steering merge and output register.
// Each accepted word's result is registered and shows on m_tdata the cycle after it.
// Throughput: one word per cycle; a new word is taken while the output register
// drains or is empty, set by the single output register stage.
// Reset (rst, synchronous, active high) restores register defaults, clears the
// trackers to 255/0, midpoints and held speeds to 0, and empties the output.
`default_nettype none
module line_sensor_calibrate_and_steer
  import lscs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // action[1:0], sample_0[9:2], sample_1, sample_2, sample_3, sample_4[41:34], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // sensor_pattern[4:0], pattern_known[5], left_drive[13:6], right_drive[21:14], zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cfg_t                cfg;
  reg_idx_t            reg_idx;
  logic                cfg_wr;
  logic                accept;
  action_t             action;
  logic [CHANNELS-1:0] pattern;
  result_t             res;
  result_t             out_res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed   <= MAX_SPEED_RST;
      cfg.slight_cut  <= SLIGHT_CUT_RST;
      cfg.sharp_cut   <= SHARP_CUT_RST;
      cfg.creep_speed <= CREEP_SPEED_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_SPEED:   cfg.max_speed   <= pwdata[SPEED_W-1:0];
        REG_SLIGHT_CUT:  cfg.slight_cut  <= pwdata[SPEED_W-1:0];
        REG_SHARP_CUT:   cfg.sharp_cut   <= pwdata[SPEED_W-1:0];
        REG_CREEP_SPEED: cfg.creep_speed <= pwdata[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_SPEED:   prdata = {24'd0, cfg.max_speed};
      REG_SLIGHT_CUT:  prdata = {24'd0, cfg.slight_cut};
      REG_SHARP_CUT:   prdata = {24'd0, cfg.sharp_cut};
      REG_CREEP_SPEED: prdata = {24'd0, cfg.creep_speed};
      default:         prdata = '0;
    endcase
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign action   = action_t'(s_tdata[ACTION_W-1:0]);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lscs_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .action (action),
      .sample (s_tdata[ACTION_W + SAMPLE_W*i +: SAMPLE_W]),
      .hit    (pattern[CHANNELS-1-i])
    );
  end

  lscs_steer u_steer (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (action),
    .pattern (pattern),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res};

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word produced no result");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !accept |=> !m_tvalid)
    else $error("taken result repeated");

  a_known_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.pattern_known |->
      ($countones(out_res.sensor_pattern) == 1 || $countones(out_res.sensor_pattern) == 2))
    else $error("known pattern with wrong bit count");

  a_nonrun_zero: assert property (@(posedge clk) disable iff (rst)
    accept && action != ACT_RUN |=> out_res.sensor_pattern == '0 && !out_res.pattern_known)
    else $error("calibration word reported a pattern");
`endif

endmodule
`default_nettype wire
